>>> design/snbp_pkg.sv
// Shared types, codes and defaults of the sigmoid neuron backprop unit.
package snbp_pkg;

    localparam int DEF_MAX_INPUTS = 64;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int ACT_W  = 4;
    localparam int IDX_W  = 6;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 17;
    localparam int KIND_W = 2;

    localparam logic [ACT_W-1:0] ACT_LOAD      = 4'd0;
    localparam logic [ACT_W-1:0] ACT_FORWARD   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_SET_RES   = 4'd2;
    localparam logic [ACT_W-1:0] ACT_BACKWARD  = 4'd3;
    localparam logic [ACT_W-1:0] ACT_SET_DELTA = 4'd4;
    localparam logic [ACT_W-1:0] ACT_GRADIENT  = 4'd5;
    localparam logic [ACT_W-1:0] ACT_ADD_MOM   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_APPLY     = 4'd7;
    localparam logic [ACT_W-1:0] ACT_CLR_MOM   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_READ      = 4'd9;

    localparam logic [KIND_W-1:0] KIND_RESULT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELTA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

    localparam logic CFG_MOMENTUM = 1'b0;
    localparam logic CFG_RATE     = 1'b1;

    localparam logic [CFG_W-1:0] RATE_RESET = 17'd6554;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] operand;
        logic signed [DATA_W-1:0] second_operand;
        logic                     last;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        logic                     saturated;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_ACC, S_SIG, S_D1, S_D2, S_D3, S_D4,
        S_G1, S_G2, S_G3, S_G4, S_OUT
    } t_state;

endpackage

>>> design/snbp_front.sv
// Input queue: accepts transactions, wraps the entry index, holds two items.
module snbp_front import snbp_pkg::*; #(
    parameter int MAX_INPUTS = DEF_MAX_INPUTS,
    localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [ACT_W-1:0]         i_action,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [DATA_W-1:0] i_operand,
    input  logic signed [DATA_W-1:0] i_second_operand,
    input  logic                     i_last,
    input  logic                     i_busy,
    output logic                     o_valid,
    output t_item                    o_item,
    output logic [AW-1:0]            o_idx,
    input  logic                     i_take
);

    t_item         r_item [2];
    logic [AW-1:0] r_idx  [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_in, w_out;

    function automatic logic [AW-1:0] f_wrap(input logic [IDX_W-1:0] v);
        logic [AW-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << IDX_W); i++) begin
            if (v == IDX_W'(i)) r = AW'(i % MAX_INPUTS);
        end
        return r;
    endfunction

    assign full    = (r_cnt == 2'd2) || i_busy;
    assign w_in    = push && !full;
    assign o_valid = (r_cnt != 2'd0);
    assign w_out   = i_take && o_valid;
    assign o_item  = r_item[r_rp];
    assign o_idx   = r_idx[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_item[r_wp] <= '{action: i_action, operand: i_operand,
                              second_operand: i_second_operand, last: i_last};
            r_idx[r_wp]  <= f_wrap(i_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in)  r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end

endmodule

>>> design/snbp_back.sv
// Execution sequencer: weight and momentum stores, shared multiplier, result queue.
module snbp_back import snbp_pkg::*; #(
    parameter int MAX_INPUTS = DEF_MAX_INPUTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    input  t_item                    i_item,
    input  logic [AW-1:0]            i_idx,
    output logic                     o_take,
    output logic                     o_busy,
    output logic                     empty,
    input  logic                     pop,
    output t_result                  o_res
);

    localparam int XW = 68;
    localparam logic signed [XW-1:0] MAX32 = XW'(64'sd2147483647);
    localparam logic signed [XW-1:0] MIN32 = -XW'(64'sd2147483648);
    localparam logic signed [XW-1:0] MAX48 = (XW'(1) <<< 47) - XW'(1);
    localparam logic signed [XW-1:0] MIN48 = -(XW'(1) <<< 47);
    localparam logic [47:0] ONE48 = 48'(1) << FRAC_BITS;
    localparam logic [47:0] TH5   = 48'(5) << FRAC_BITS;
    localparam logic [47:0] TH19  = 48'(19) << (FRAC_BITS - 3);
    localparam logic [47:0] OFS27 = 48'(27) << (FRAC_BITS - 5);
    localparam logic [47:0] OFS5  = 48'(5) << (FRAC_BITS - 3);
    localparam logic signed [32:0] ONE33 = 33'(1) <<< FRAC_BITS;

    function automatic logic f_ovf32(input logic signed [XW-1:0] x);
        return (x > MAX32) || (x < MIN32);
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [XW-1:0] x);
        if (x > MAX32) return 32'sh7FFFFFFF;
        if (x < MIN32) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic f_ovf48(input logic signed [XW-1:0] x);
        return (x > MAX48) || (x < MIN48);
    endfunction

    function automatic logic signed [47:0] f_sat48(input logic signed [XW-1:0] x);
        if (x > MAX48) return MAX48[47:0];
        if (x < MIN48) return MIN48[47:0];
        return x[47:0];
    endfunction

    logic signed [31:0] r_wmem [MAX_INPUTS];
    logic signed [31:0] r_mmem [MAX_INPUTS];

    t_state             r_state, n_state;
    logic [AW-1:0]      r_ccnt;
    t_item              r_item;
    logic [AW-1:0]      r_idx;
    logic signed [31:0] r_wrd, r_mrd;
    logic [CFG_W-1:0]   r_momentum, r_rate;
    logic signed [47:0] r_acc, n_acc;
    logic               r_accsat, n_accsat;
    logic signed [31:0] r_result, n_result;
    logic signed [31:0] r_delta, n_delta;
    logic signed [31:0] r_s, n_s, r_t, n_t;
    logic signed [48:0] r_mom, n_mom;
    logic               r_sat, n_sat;
    logic signed [65:0] r_prod;
    logic signed [32:0] w_ma, w_mb;
    logic signed [XW-1:0] w_asrp;
    t_result            r_res, n_res;
    logic               w_wwe, w_mwe;
    logic [AW-1:0]      w_maddr;
    logic signed [31:0] w_wdata, w_mdata;

    t_result            r_oq [2];
    logic               r_owp, r_orp;
    logic [1:0]         r_ocnt;
    logic               w_opush, w_opop;

    logic signed [XW-1:0] w_p, w_sum, w_x;
    logic signed [47:0]   w_p48;
    logic [47:0]          w_abs, w_y;
    logic signed [31:0]   w_v;

    assign w_asrp = $signed({{2{r_prod[65]}}, r_prod}) >>> FRAC_BITS;
    assign o_busy = (r_state == S_CLEAR);
    assign o_take = (r_state == S_IDLE) && i_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_ccnt == AW'(MAX_INPUTS - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_valid) n_state = S_EXEC;
            S_EXEC: begin
                unique case (r_item.action)
                    ACT_FORWARD, ACT_BACKWARD: n_state = S_ACC;
                    ACT_GRADIENT:              n_state = S_G1;
                    ACT_READ:                  n_state = S_OUT;
                    default:                   n_state = S_IDLE;
                endcase
            end
            S_ACC: begin
                if (!r_item.last) n_state = S_IDLE;
                else if (r_item.action == ACT_FORWARD) n_state = S_SIG;
                else n_state = S_D1;
            end
            S_SIG:   n_state = S_OUT;
            S_D1:    n_state = S_D2;
            S_D2:    n_state = S_D3;
            S_D3:    n_state = S_D4;
            S_D4:    n_state = S_OUT;
            S_G1:    n_state = S_G2;
            S_G2:    n_state = S_G3;
            S_G3:    n_state = S_G4;
            S_G4:    n_state = S_OUT;
            S_OUT:   if (r_ocnt != 2'd2) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_acc    = r_acc;
        n_accsat = r_accsat;
        n_result = r_result;
        n_delta  = r_delta;
        n_s      = r_s;
        n_t      = r_t;
        n_mom    = r_mom;
        n_sat    = r_sat;
        n_res    = r_res;
        w_ma     = '0;
        w_mb     = '0;
        w_wwe    = 1'b0;
        w_wdata  = r_item.operand;
        w_mwe    = 1'b0;
        w_maddr  = r_idx;
        w_mdata  = '0;
        w_opush  = 1'b0;
        w_p      = '0;
        w_p48    = '0;
        w_sum    = '0;
        w_x      = '0;
        w_abs    = '0;
        w_y      = '0;
        w_v      = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_mwe   = 1'b1;
                w_maddr = r_ccnt;
            end
            S_EXEC: begin
                n_sat = 1'b0;
                unique case (r_item.action)
                    ACT_LOAD:      w_wwe = 1'b1;
                    ACT_FORWARD: begin
                        w_ma = 33'(r_item.operand);
                        w_mb = 33'(r_wrd);
                    end
                    ACT_SET_RES:   n_result = r_item.operand;
                    ACT_BACKWARD: begin
                        w_ma = 33'(r_item.operand);
                        w_mb = 33'(r_item.second_operand);
                    end
                    ACT_SET_DELTA: n_delta = r_item.operand;
                    ACT_GRADIENT: begin
                        w_ma = $signed({16'b0, r_momentum});
                        w_mb = 33'(r_mrd);
                    end
                    ACT_ADD_MOM: begin
                        w_mwe   = 1'b1;
                        w_mdata = f_sat32(XW'(r_mrd) + XW'(r_item.operand));
                    end
                    ACT_APPLY: begin
                        w_wwe   = 1'b1;
                        w_wdata = f_sat32(XW'(r_wrd) + XW'(r_item.operand));
                    end
                    ACT_CLR_MOM:   w_mwe = 1'b1;
                    ACT_READ:      n_res = '{kind: KIND_READ, value: r_wrd, saturated: 1'b0};
                    default: ;
                endcase
            end
            S_ACC: begin
                w_p48    = f_sat48(w_asrp);
                w_sum    = XW'(r_acc) + XW'(w_p48);
                n_acc    = f_sat48(w_sum);
                n_accsat = r_accsat || f_ovf48(w_asrp) || f_ovf48(w_sum);
            end
            S_SIG: begin
                w_x   = XW'(r_acc);
                w_p   = -w_x;
                w_abs = r_acc[47] ? w_p[47:0] : w_x[47:0];
                if (w_abs >= TH5)       w_y = ONE48;
                else if (w_abs >= TH19) w_y = (w_abs >> 5) + OFS27;
                else if (w_abs >= ONE48) w_y = (w_abs >> 3) + OFS5;
                else                    w_y = (w_abs >> 2) + (ONE48 >> 1);
                if (r_acc[47]) w_y = ONE48 - w_y;
                n_result = w_y[31:0];
                n_res    = '{kind: KIND_RESULT, value: w_y[31:0], saturated: r_accsat};
                n_acc    = '0;
                n_accsat = 1'b0;
            end
            S_D1: begin
                w_ma  = 33'(r_result);
                w_mb  = ONE33 - 33'(r_result);
                n_s   = f_sat32(XW'(r_acc));
                n_sat = r_accsat || f_ovf32(XW'(r_acc));
            end
            S_D2: begin
                n_t   = f_sat32(w_asrp);
                n_sat = r_sat || f_ovf32(w_asrp);
            end
            S_D3: begin
                w_ma = 33'(r_t);
                w_mb = 33'(r_s);
            end
            S_D4: begin
                w_v      = f_sat32(w_asrp);
                n_delta  = w_v;
                n_res    = '{kind: KIND_DELTA, value: w_v,
                             saturated: r_sat || f_ovf32(w_asrp)};
                n_acc    = '0;
                n_accsat = 1'b0;
            end
            S_G1: begin
                n_mom = w_asrp[48:0];
                w_ma  = 33'(r_delta);
                w_mb  = 33'(r_item.operand);
            end
            S_G2: begin
                n_t   = f_sat32(w_asrp);
                n_sat = r_sat || f_ovf32(w_asrp);
            end
            S_G3: begin
                w_ma = $signed({16'b0, r_rate});
                w_mb = 33'(r_t);
            end
            S_G4: begin
                w_sum = XW'(r_mom) + w_asrp;
                n_res = '{kind: KIND_CHANGE, value: f_sat32(w_sum),
                          saturated: r_sat || f_ovf32(w_sum)};
            end
            S_OUT: w_opush = (r_ocnt != 2'd2);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wwe) r_wmem[r_idx] <= w_wdata;
        if (w_mwe) r_mmem[w_maddr] <= w_mdata;
        if (o_take) begin
            r_wrd  <= r_wmem[i_idx];
            r_mrd  <= r_mmem[i_idx];
            r_item <= i_item;
            r_idx  <= i_idx;
        end
        r_prod <= w_ma * w_mb;
        r_s    <= n_s;
        r_t    <= n_t;
        r_mom  <= n_mom;
        r_sat  <= n_sat;
        r_res  <= n_res;
        if (w_opush) r_oq[r_owp] <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_ccnt     <= '0;
            r_momentum <= '0;
            r_rate     <= RATE_RESET;
            r_acc      <= '0;
            r_accsat   <= 1'b0;
            r_result   <= '0;
            r_delta    <= '0;
            r_owp      <= 1'b0;
            r_orp      <= 1'b0;
            r_ocnt     <= 2'd0;
        end else begin
            r_state  <= n_state;
            if (r_state == S_CLEAR) r_ccnt <= r_ccnt + AW'(1);
            if (i_cfg_we && i_cfg_idx == CFG_MOMENTUM) r_momentum <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_RATE)     r_rate     <= i_cfg_data;
            r_acc    <= n_acc;
            r_accsat <= n_accsat;
            r_result <= n_result;
            r_delta  <= n_delta;
            if (w_opush) r_owp <= ~r_owp;
            if (w_opop)  r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + 2'(w_opush) - 2'(w_opop);
        end
    end

    assign empty  = (r_ocnt == 2'd0);
    assign w_opop = pop && !empty;
    assign o_res  = r_oq[r_orp];

endmodule

>>> design/sigmoid_neuron_backprop_unit_top.sv
// Top level of the sigmoid neuron backprop unit.
// Usage: push a transaction (action, index, operand, second_operand, last)
// while full is low; results come out oldest first and are taken with pop
// while empty is low, as kind, value and saturated.
// Configuration: write momentum (index 0) or learning_rate (index 1) with
// i_cfg_we; do so only while no transaction is in flight.
// Sequence: an item is registered in the input queue; the sequencer takes it
// only when idle and finishes it before taking the next. Store and set
// actions execute and return to idle; forward and backward elements also
// accumulate; a forward with last adds the sigmoid step, a backward with
// last the delta steps; a gradient runs the gradient steps; these and a
// weight read end in the output step. All products come from one shared multiplier.
// Reset: synchronous, active low. After reset a clearing pass zeroes the
// momentum store; full stays high throughout it.
// Weight entries hold no value until loaded.
// Stalls: a two-entry result queue absorbs results; when it is full the
// sequencer holds its result, and the input queue fills and raises full.
module sigmoid_neuron_backprop_unit_top import snbp_pkg::*; #(
    parameter int MAX_INPUTS = DEF_MAX_INPUTS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [ACT_W-1:0]         i_action,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [DATA_W-1:0] i_operand,
    input  logic signed [DATA_W-1:0] i_second_operand,
    input  logic                     i_last,
    output logic                     empty,
    input  logic                     pop,
    output logic [KIND_W-1:0]        o_kind,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_saturated,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    logic          w_valid, w_take, w_busy;
    t_item         w_item;
    logic [AW-1:0] w_idx;
    t_result       w_res;

    snbp_front #(.MAX_INPUTS(MAX_INPUTS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_index          (i_index),
        .i_operand        (i_operand),
        .i_second_operand (i_second_operand),
        .i_last           (i_last),
        .i_busy           (w_busy),
        .o_valid          (w_valid),
        .o_item           (w_item),
        .o_idx            (w_idx),
        .i_take           (w_take)
    );

    snbp_back #(.MAX_INPUTS(MAX_INPUTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .i_idx      (w_idx),
        .o_take     (w_take),
        .o_busy     (w_busy),
        .empty      (empty),
        .pop        (pop),
        .o_res      (w_res)
    );

    assign o_kind      = w_res.kind;
    assign o_value     = w_res.value;
    assign o_saturated = w_res.saturated;

endmodule
